FILE: design/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
`timescale 1ns / 1ps

package sfr_pkg;

    // Width of the length registers and of the replacement byte index.
    localparam int LEN_W = 4;
    // Configuration address width: four registers at 8-byte spacing.
    localparam int ADDR_W = 5;
    // Upper bound on the replacement length.
    localparam logic [LEN_W-1:0] REPLACE_MAX = 4'd8;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_SEARCH_PATTERN     = 2'd0;
    localparam logic [1:0] REG_SEARCH_LENGTH      = 2'd1;
    localparam logic [1:0] REG_REPLACEMENT_TEXT   = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT_LENGTH = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } t_out_item;

    typedef struct packed {
        logic [63:0]      search_pattern;
        logic [LEN_W-1:0] search_length;
        logic [63:0]      replacement_text;
        logic [LEN_W-1:0] replacement_length;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // append the input byte to the window
        logic emit_win;    // release the first window byte and shift
        logic emit_repl;   // emit the next replacement byte
        logic clr_count;   // full match: empty the window
        logic flush_pend;  // push the pending byte out as the run's last
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic match_ok;    // window is a prefix of the pattern
        logic full_match;  // window length equals the pattern length
        logic count_zero;
        logic repl_done;
        logic last;
        logic pend_valid;
        logic emit_ready;  // an emit can be taken this cycle
        logic out_free;    // output register can load this cycle
    } t_dp_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_REPL,
        ST_FLUSH,
        ST_DONE
    } t_state;

endpackage

FILE: design/sfr_datapath.sv
// Datapath: match window, replacement index, pending byte and output register.
`timescale 1ns / 1ps

module sfr_datapath import sfr_pkg::*; #(
    parameter int PATTERN_MAX = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    input  t_in_item  i_in_data,
    input  t_cfg      i_cfg,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int NW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [7:0]       r_win [PATTERN_MAX];
    logic [NW-1:0]    r_count, n_count;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic             r_last;
    logic             r_pend_valid, n_pend_valid;
    logic [7:0]       r_pend_byte, n_pend_byte;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    logic [LEN_W-1:0] plen;
    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] count_ext;
    logic [PATTERN_MAX-1:0] byte_ok;
    logic [7:0]       repl_byte;
    logic [7:0]       emit_byte;
    logic             do_emit;
    logic             out_free;

    // Active lengths: a zero search length acts as one, both saturate.
    always_comb begin
        if (i_cfg.search_length == '0) begin
            plen = LEN_W'(1);
        end else if (i_cfg.search_length > LEN_W'(PATTERN_MAX)) begin
            plen = LEN_W'(PATTERN_MAX);
        end else begin
            plen = i_cfg.search_length;
        end
        if (i_cfg.replacement_length > REPLACE_MAX) begin
            rlen = REPLACE_MAX;
        end else begin
            rlen = i_cfg.replacement_length;
        end
    end

    assign count_ext = LEN_W'(r_count);

    // Entries at or above the count are not part of the window.
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            byte_ok[i] = (i >= int'(r_count)) ||
                         (r_win[i] == i_cfg.search_pattern[8*i +: 8]);
        end
    end

    assign repl_byte = i_cfg.replacement_text[{r_idx[2:0], 3'b000} +: 8];
    assign emit_byte = i_cmd.emit_win ? r_win[0] : repl_byte;
    assign do_emit   = i_cmd.emit_win || i_cmd.emit_repl;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.match_ok   = (count_ext <= plen) && (&byte_ok);
        o_stat.full_match = (count_ext == plen);
        o_stat.count_zero = (r_count == '0);
        o_stat.repl_done  = (r_idx == rlen);
        o_stat.last       = r_last;
        o_stat.pend_valid = r_pend_valid;
        o_stat.emit_ready = !r_pend_valid || out_free;
        o_stat.out_free   = out_free;
    end

    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;

        if (i_cmd.load) begin
            n_count = r_count + NW'(1);
            n_idx   = '0;
        end
        if (i_cmd.emit_win) begin
            n_count = r_count - NW'(1);
        end
        if (i_cmd.clr_count) begin
            n_count = '0;
        end
        if (i_cmd.emit_repl) begin
            n_idx = r_idx + LEN_W'(1);
        end

        // Each emitted byte waits in the pending slot until it is known
        // whether another byte of the same run follows it.
        if (do_emit) begin
            if (r_pend_valid) begin
                n_out_valid        = 1'b1;
                n_out.out_byte     = r_pend_byte;
                n_out.run_last     = 1'b0;
                n_out.text_done    = 1'b0;
            end
            n_pend_valid = 1'b1;
            n_pend_byte  = emit_byte;
        end
        if (i_cmd.flush_pend) begin
            n_out_valid     = 1'b1;
            n_out.out_byte  = r_pend_byte;
            n_out.run_last  = 1'b1;
            n_out.text_done = r_last;
            n_pend_valid    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_byte <= n_pend_byte;
        r_out       <= n_out;
        if (i_cmd.load) begin
            r_last                    <= i_in_data.end_of_text;
            r_win[r_count[IW-1:0]]    <= i_in_data.in_byte;
        end
        if (i_cmd.emit_win) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/sfr_ctrl.sv
// Controller state machine that sequences one input transfer at a time.
`timescale 1ns / 1ps

module sfr_ctrl import sfr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Release leading bytes until the window is a pattern prefix.
                if (!i_stat.match_ok) begin
                    o_cmd.emit_win = i_stat.emit_ready;
                end else if (i_stat.full_match) begin
                    o_cmd.clr_count = 1'b1;
                    n_state         = ST_REPL;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_REPL: begin
                if (!i_stat.repl_done) begin
                    o_cmd.emit_repl = i_stat.emit_ready;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (i_stat.last && !i_stat.count_zero) begin
                    o_cmd.emit_win = i_stat.emit_ready;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!i_stat.pend_valid) begin
                    n_state = ST_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush_pend = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/stream_find_replace.sv
// Top level of the stream find-and-replace block with its register port.
`timescale 1ns / 1ps

// Streaming find-and-replace-all over a byte stream. Each input transfer
// carries one byte; every leftmost, non-overlapping occurrence of the search
// pattern (1 to PATTERN_MAX bytes, first byte in bits 7..0) is replaced by the
// replacement text (0 to 8 bytes), and all other bytes pass through in order.
// end_of_text flushes the held bytes; run_last marks the last output byte of
// each input, text_done the last output byte of an end_of_text input. Inputs
// that produce nothing give no output. Items are handled one at a time by a
// controller that emits one byte per cycle while the output is not stalled.
// Registers: search_pattern at 0x00, search_length at 0x08, replacement_text at
// 0x10, replacement_length at 0x18; the user must write them only while the
// block is idle, which the block itself does not enforce.
module stream_find_replace import sfr_pkg::*; #(
    parameter int PATTERN_MAX = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    t_cfg     r_cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     cfg_write;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[4:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.search_pattern     <= '0;
            r_cfg.search_length      <= LEN_W'(1);
            r_cfg.replacement_text   <= '0;
            r_cfg.replacement_length <= '0;
        end else if (cfg_write) begin
            case (reg_index)
                REG_SEARCH_PATTERN:     r_cfg.search_pattern     <= pwdata;
                REG_SEARCH_LENGTH:      r_cfg.search_length      <= pwdata[LEN_W-1:0];
                REG_REPLACEMENT_TEXT:   r_cfg.replacement_text   <= pwdata;
                REG_REPLACEMENT_LENGTH: r_cfg.replacement_length <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_SEARCH_PATTERN:     prdata = r_cfg.search_pattern;
            REG_SEARCH_LENGTH:      prdata = 64'(r_cfg.search_length);
            REG_REPLACEMENT_TEXT:   prdata = r_cfg.replacement_text;
            REG_REPLACEMENT_LENGTH: prdata = 64'(r_cfg.replacement_length);
            default:                prdata = '0;
        endcase
    end

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sfr_datapath #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: design/sfr_checker.sv
// Port-level checks for the stream find-and-replace block, bound to the top.
`timescale 1ns / 1ps

module sfr_checker import sfr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data,
    input logic      pready
);

    // A stalled output transfer keeps its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output transfer changed while stalled");

    // The end of a text is always the end of that input's run.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.text_done) |-> o_out_data.run_last)
        else $error("text_done without run_last");

    // After an input transfer the block is busy with that byte.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted on back-to-back cycles");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);

FILE: tb/stream_find_replace_test.sv
// Self-checking testbench for the stream find-and-replace block.
`timescale 1ns / 1ps

module stream_find_replace_test;
    import sfr_pkg::*;

    localparam int PATTERN_MAX     = 8;
    localparam int DRAIN_CYCLES    = 64;
    localparam int IDLE_LIMIT      = 4000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_BYTES     = 35;
    localparam int MAX_REPORTS     = 10;
    localparam int CHECK_PREDICTED = -1;
    localparam int KEEP_SETTING    = -1;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_FOURTH,
        STALL_BURSTS
    } t_stall_mode;

    // One directed text byte; typed_n is the number of results typed in here
    // (zero or one), or CHECK_PREDICTED to take them from the predictor.
    typedef struct {
        int         setting;
        logic [7:0] data;
        logic       eot;
        int         typed_n;
        logic [7:0] typed_b;
    } t_dir_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [63:0]       pwdata      = '0;
    logic [63:0]       prdata;
    logic              pready;

    // Register copies and window state of the predictor.
    logic [63:0] srch_pat = 64'h0;
    logic [3:0]  srch_len = 4'd1;
    logic [63:0] repl_txt = 64'h0;
    logic [3:0]  repl_len = 4'd0;
    logic [63:0] held_win = 64'h0;
    int          held_cnt = 0;

    t_out_item step_bytes[$];
    t_out_item edited_q[$];
    t_out_item want;

    int          errors      = 0;
    int          idle_cycles = 0;
    int          burst_left  = 0;
    int          bytes_sent  = 0;
    bit          hold_req    = 1'b0;
    int          hold_left   = 0;
    int          mode_left   = 0;
    t_stall_mode stall_mode  = STALL_NONE;

    t_cfg dir_settings [0:2] = '{
        '{64'h6261, 4'd2, 64'h5A5958, 4'd3},
        '{64'hFF, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0, 4'd8}
    };

    t_dir_row dir_rows [0:22] = '{
        // Reset registers: a one-byte pattern of 0x00 that is deleted.
        '{KEEP_SETTING, 8'hFF, 1'b0, 1, 8'hFF},
        '{KEEP_SETTING, 8'h00, 1'b0, 0, 8'h00},
        '{KEEP_SETTING, 8'h00, 1'b1, 0, 8'h00},
        '{KEEP_SETTING, 8'h80, 1'b1, 1, 8'h80},
        '{KEEP_SETTING, 8'h01, 1'b0, 1, 8'h01},
        // "ab" becomes "XYZ"; a false start, a flush, and a byte left held.
        '{0, 8'h61, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'h62, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'h61, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'h61, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'h62, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'h61, 1'b1, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'h61, 1'b0, CHECK_PREDICTED, 8'h00},
        // Zero search length and an oversized replacement length.
        '{1, 8'hFF, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'h00, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'hFF, 1'b1, CHECK_PREDICTED, 8'h00},
        // Oversized search length: seven pattern bytes, then a plain byte that breaks the match.
        '{2, 8'hFF, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'hFF, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'hFF, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'hFF, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'hFF, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'hFF, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'hFF, 1'b0, CHECK_PREDICTED, 8'h00},
        '{KEEP_SETTING, 8'h00, 1'b0, CHECK_PREDICTED, 8'h00}
    };

    stream_find_replace #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 i_clk = ~i_clk;

    function automatic int active_search_len();
        int n;
        n = srch_len;
        if (n == 0) n = 1;
        if (n > PATTERN_MAX) n = PATTERN_MAX;
        return n;
    endfunction

    function automatic bit window_fits(logic [63:0] w, int n, int plen);
        if (n > plen) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (w[8*i +: 8] != srch_pat[8*i +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void add_out(logic [7:0] b);
        step_bytes.push_back(t_out_item'{out_byte: b, run_last: 1'b0, text_done: 1'b0});
    endfunction

    // Advances the window by one text byte and collects the edited bytes it
    // releases in step_bytes.
    function automatic void edit_step(t_in_item it);
        logic [63:0] w;
        int          n;
        int          plen;
        int          rlen;
        t_out_item   tail;
        step_bytes.delete();
        plen = active_search_len();
        n = (held_cnt > PATTERN_MAX - 1) ? PATTERN_MAX - 1 : held_cnt;
        w = held_win;
        w[8*n +: 8] = it.in_byte;
        n++;
        while (n > 0 && !window_fits(w, n, plen)) begin
            add_out(w[7:0]);
            w = w >> 8;
            n--;
        end
        if (n == plen) begin
            rlen = (repl_len > REPLACE_MAX) ? int'(REPLACE_MAX) : int'(repl_len);
            for (int i = 0; i < rlen; i++) add_out(repl_txt[8*i +: 8]);
            n = 0;
        end
        if (it.end_of_text) begin
            for (int i = 0; i < n; i++) add_out(w[8*i +: 8]);
            n = 0;
        end
        held_win = w;
        held_cnt = n;
        if (step_bytes.size() > 0) begin
            tail = step_bytes[step_bytes.size() - 1];
            tail.run_last = 1'b1;
            tail.text_done = it.end_of_text;
            step_bytes[step_bytes.size() - 1] = tail;
        end
    endfunction

    function automatic t_cfg random_setting();
        t_cfg       c;
        logic [7:0] a;
        logic [7:0] b;
        a = 8'($urandom);
        b = 8'($urandom);
        // A two-letter pattern makes partial matches and rescans common.
        for (int i = 0; i < 8; i++) c.search_pattern[8*i +: 8] = $urandom_range(0, 1) ? a : b;
        if ($urandom_range(0, 3) == 0) c.search_pattern = {$urandom, $urandom};
        c.search_length = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(1, 8));
        c.replacement_text = {$urandom, $urandom};
        c.replacement_length = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                           : 4'($urandom_range(0, 8));
        return c;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SEARCH_PATTERN:     srch_pat = value;
            REG_SEARCH_LENGTH:      srch_len = value[3:0];
            REG_REPLACEMENT_TEXT:   repl_txt = value;
            REG_REPLACEMENT_LENGTH: repl_len = value[3:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(t_cfg c);
        write_reg(REG_SEARCH_PATTERN, c.search_pattern);
        write_reg(REG_SEARCH_LENGTH, 64'(c.search_length));
        write_reg(REG_REPLACEMENT_TEXT, c.replacement_text);
        write_reg(REG_REPLACEMENT_LENGTH, 64'(c.replacement_length));
    endtask

    // Stops offering text, then waits for every edited byte and for any
    // byte that produces no output to work its way through.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (edited_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_byte(t_in_item it, int typed_n, logic [7:0] typed_b);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        edit_step(it);
        if (typed_n == CHECK_PREDICTED) begin
            foreach (step_bytes[k]) edited_q.push_back(step_bytes[k]);
        end else if (typed_n == 1) begin
            edited_q.push_back(t_out_item'{out_byte: typed_b, run_last: 1'b1,
                                           text_done: it.end_of_text});
        end
    endtask

    // Sends a short run of text shaped around the current pattern: whole
    // matches, broken prefixes, pattern letters and plain noise.
    task automatic send_random_run();
        int       r;
        int       plen;
        int       cut;
        int       k;
        t_in_item it;
        plen = active_search_len();
        r = $urandom_range(0, 9);
        if (r <= 3) begin
            for (k = 0; k < plen; k++) begin
                it.in_byte = srch_pat[8*k +: 8];
                it.end_of_text = (k == plen - 1) && ($urandom_range(0, 11) == 0);
                send_byte(it, CHECK_PREDICTED, 8'h00);
            end
        end else if (r <= 5) begin
            cut = $urandom_range(0, plen - 1);
            for (k = 0; k < cut; k++) begin
                it.in_byte = srch_pat[8*k +: 8];
                it.end_of_text = 1'b0;
                send_byte(it, CHECK_PREDICTED, 8'h00);
            end
            k = $urandom_range(0, plen - 1);
            it.in_byte = $urandom_range(0, 1) ? srch_pat[8*k +: 8] : 8'($urandom);
            it.end_of_text = ($urandom_range(0, 19) == 0);
            send_byte(it, CHECK_PREDICTED, 8'h00);
        end else if (r <= 7) begin
            k = $urandom_range(0, plen - 1);
            it.in_byte = srch_pat[8*k +: 8];
            it.end_of_text = ($urandom_range(0, 19) == 0);
            send_byte(it, CHECK_PREDICTED, 8'h00);
        end else begin
            it.in_byte = 8'($urandom);
            it.end_of_text = (r == 9);
            send_byte(it, CHECK_PREDICTED, 8'h00);
        end
    endtask

    // Receiver: switches among random stall patterns, and once
    // holds off long enough for the block to back up into its input.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 4));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                STALL_NONE:         i_out_stall <= 1'b0;
                STALL_LIGHT:        i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:        i_out_stall <= ($urandom_range(0, 3) != 0);
                STALL_EVERY_FOURTH: i_out_stall <= (mode_left % 4 == 0);
                default:            i_out_stall <= ((mode_left / 6) % 2 == 1);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (edited_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("unexpected output transfer: byte %h last %b done %b",
                                 o_out_data.out_byte, o_out_data.run_last,
                                 o_out_data.text_done);
                    end
                end else begin
                    want = edited_q.pop_front();
                    if (o_out_data.out_byte !== want.out_byte
                            || o_out_data.run_last !== want.run_last
                            || o_out_data.text_done !== want.text_done) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("mismatch: expected %h/%b/%b, got %h/%b/%b (byte/last/done)",
                                     want.out_byte, want.run_last, want.text_done,
                                     o_out_data.out_byte, o_out_data.run_last,
                                     o_out_data.text_done);
                        end
                    end
                end
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_in_item it;
        t_cfg     cfg;
        int       phase_start;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].setting != KEEP_SETTING) begin
                wait_idle();
                apply_setting(dir_settings[dir_rows[k].setting]);
            end
            it.in_byte = dir_rows[k].data;
            it.end_of_text = dir_rows[k].eot;
            send_byte(it, dir_rows[k].typed_n, dir_rows[k].typed_b);
        end

        // Settings change without a flush, so held bytes meet new lengths.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            cfg = random_setting();
            if (ph == 0) begin
                cfg.search_length = 4'd8;
                cfg.replacement_length = 4'd8;
            end else if (ph == 1) begin
                cfg.search_length = 4'd1;
                cfg.replacement_length = 4'd0;
            end
            wait_idle();
            apply_setting(cfg);
            if (ph == 0) hold_req = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) send_random_run();
        end

        wait_idle();
        if (errors == 0 && edited_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/sfr_pkg.sv
design/sfr_datapath.sv
design/sfr_ctrl.sv
design/stream_find_replace.sv
design/sfr_checker.sv
tb/stream_find_replace_test.sv
